FILE: src/mat_pkg.sv
// mat_pkg: shared types, codes and sizes for the masked address table
// used by the channel interfaces, the entry ram and the top level
`timescale 1ns / 1ps

package mat_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = 32;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 11;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [FUNC_W-1:0] OP_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] OP_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] OP_MATCH  = 2'd2;
    localparam logic [FUNC_W-1:0] OP_FLUSH  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EXISTS    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_DONE
    } mat_state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] mask;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

endpackage

FILE: src/mat_req_if.sv
// mat_req_if: request channel of the masked address table
// depends on mat_pkg for field widths
`timescale 1ns / 1ps

interface mat_req_if
    import mat_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] mask;

    modport source (output valid, output func, output addr, output mask, input ready);
    modport sink   (input valid, input func, input addr, input mask, output ready);
endinterface

FILE: src/mat_rsp_if.sv
// mat_rsp_if: response channel of the masked address table
// depends on mat_pkg for field widths
`timescale 1ns / 1ps

interface mat_rsp_if
    import mat_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic                   matched;
    logic [COUNT_OUT_W-1:0] entry_count;

    modport source (output valid, output status, output matched, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input matched, input entry_count,
                    output ready);
endinterface

FILE: src/mat_entry_ram.sv
// mat_entry_ram: one write port, one registered read port store of entries
// depends on mat_pkg for entry_t and ram_req_t
`timescale 1ns / 1ps

module mat_entry_ram
    import mat_pkg::*;
(
    input  logic     clk,
    input  ram_req_t req,
    output entry_t   rd_data
);

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/masked_address_table.sv
// masked_address_table: top level, sequencer scanning the packed entry store
// depends on mat_pkg, mat_req_if, mat_rsp_if and mat_entry_ram
//
//  channel | dir | fields                          | transaction
//  req     | in  | func, addr, mask                | valid && ready
//  rsp     | out | status, matched, entry_count    | valid && ready
//
// valid entries are kept packed in slots 0 .. count-1; delete moves the last
// entry into the freed slot, so no per-entry valid bits exist
// one comparator scans one stored entry per cycle through the ram read port;
// append and match end at a hit or once the scan is exhausted, delete on a hit
// then reads the last entry and writes it into the freed slot, and flush and
// append on a full table go straight to the response without a scan
// reset clears the entry count but not the stored entries; no clearing pass is needed
// req is ready only while idle; a waiting response is held in its own
// register, so the next transaction may be taken while rsp is stalled
`timescale 1ns / 1ps

module masked_address_table
    import mat_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    mat_req_if.sink       req,
    mat_rsp_if.source     rsp
);

    mat_state_t          state_reg, state_next;
    logic [FUNC_W-1:0]   op_reg, op_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [ADDR_W-1:0]   mask_reg, mask_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                matched_reg, matched_next;

    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;
    logic                   out_matched_reg, out_matched_next;
    logic [COUNT_OUT_W-1:0] out_count_reg, out_count_next;

    ram_req_t    ram_req;
    entry_t      rd_entry;
    logic        hit;
    logic [31:0] count_wide;
    logic [CNT_W-1:0] last_idx;

    mat_entry_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_entry)
    );

    // compare the entry read in the previous cycle
    always_comb
    begin
        if (op_reg == OP_MATCH)
        begin
            hit = pend_reg && (rd_entry.addr == (addr_reg & rd_entry.mask));
        end
        else
        begin
            hit = pend_reg && (rd_entry.addr == addr_reg) && (rd_entry.mask == mask_reg);
        end
    end

    assign last_idx   = count_reg - CNT_W'(1);
    assign count_wide = 32'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        addr_reg        <= addr_next;
        mask_reg        <= mask_next;
        rd_idx_reg      <= rd_idx_next;
        pend_idx_reg    <= pend_idx_next;
        hit_idx_reg     <= hit_idx_next;
        status_reg      <= status_next;
        matched_reg     <= matched_next;
        out_status_reg  <= out_status_next;
        out_matched_reg <= out_matched_next;
        out_count_reg   <= out_count_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        addr_next        = addr_reg;
        mask_next        = mask_reg;
        count_next       = count_reg;
        rd_idx_next      = rd_idx_reg;
        pend_next        = 1'b0;
        pend_idx_next    = pend_idx_reg;
        hit_idx_next     = hit_idx_reg;
        status_next      = status_reg;
        matched_next     = matched_reg;
        out_status_next  = out_status_reg;
        out_matched_next = out_matched_reg;
        out_count_next   = out_count_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        ram_req          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next      = req.func;
                    addr_next    = req.addr;
                    mask_next    = req.mask;
                    status_next  = STATUS_OK;
                    matched_next = 1'b0;
                    rd_idx_next  = '0;
                    case (req.func)
                        OP_FLUSH:
                        begin
                            count_next = '0;
                            state_next = ST_DONE;
                        end
                        OP_APPEND:
                        begin
                            if (count_reg >= CNT_W'(TABLE_DEPTH))
                            begin
                                status_next = STATUS_FULL;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_SCAN;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (hit)
                begin
                    case (op_reg)
                        OP_APPEND:
                        begin
                            status_next = STATUS_EXISTS;
                            state_next  = ST_DONE;
                        end
                        OP_DELETE:
                        begin
                            hit_idx_next = pend_idx_reg;
                            state_next   = ST_MOVE_RD;
                        end
                        OP_MATCH:
                        begin
                            matched_next = 1'b1;
                            state_next   = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
                else if (rd_idx_reg < count_reg)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = rd_idx_reg[IDX_W-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next   = rd_idx_reg + CNT_W'(1);
                end
                else if (!pend_reg)
                begin
                    // scan exhausted with no hit
                    case (op_reg)
                        OP_APPEND:
                        begin
                            ram_req.we         = 1'b1;
                            ram_req.waddr      = count_reg[IDX_W-1:0];
                            ram_req.wdata.addr = addr_reg;
                            ram_req.wdata.mask = mask_reg;
                            count_next         = count_reg + CNT_W'(1);
                        end
                        OP_DELETE:
                        begin
                            status_next = STATUS_NOT_FOUND;
                        end
                        default:
                        begin
                        end
                    endcase
                    state_next = ST_DONE;
                end
            end

            ST_MOVE_RD:
            begin
                // fetch the last entry to fill the hole
                ram_req.re    = 1'b1;
                ram_req.raddr = last_idx[IDX_W-1:0];
                state_next    = ST_MOVE_WR;
            end

            ST_MOVE_WR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = hit_idx_reg;
                ram_req.wdata = rd_entry;
                count_next    = last_idx;
                state_next    = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = status_reg;
                    out_matched_next = matched_reg;
                    out_count_next   = count_wide[COUNT_OUT_W-1:0];
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.matched     = out_matched_reg;
    assign rsp.entry_count = out_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.func == OP_FLUSH) |=> (count_reg == '0))
        else $error("flush did not empty the table");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> (CNT_W'(ram_req.waddr) <= count_reg))
        else $error("entry write outside the packed region");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !rsp.ready) |=> (state_reg == ST_DONE))
        else $error("response register overwritten while stalled");

endmodule

FILE: test/tb_masked_address_table.sv
// tb_masked_address_table: self-checking bench for the masked address table
// needs mat_pkg, mat_req_if, mat_rsp_if and the masked_address_table rtl
// runs directed and random traffic against a queue-based table predictor
`timescale 1ns / 1ps

module tb_masked_address_table;
    import mat_pkg::*;

    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int TABLE_CAP   = 64;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic                   matched;
        logic [COUNT_OUT_W-1:0] count;
    } table_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    mat_req_if req_ch ();
    mat_rsp_if rsp_ch ();

    masked_address_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #6 clk = ~clk;

    // predictor state: the stored pairs, order does not matter
    entry_t     stored[$];
    table_rsp_t pending_rsp[$];

    bit          no_idle = 1'b0;
    int          errors = 0;
    int unsigned cycles = 0;
    int unsigned op_seen[4];
    int unsigned full_seen, dup_seen, miss_seen, hit_seen, peak_entries;

    function automatic int find_pair(input logic [ADDR_W-1:0] a, input logic [ADDR_W-1:0] m);
        for (int k = 0; k < stored.size(); k++)
        begin
            if (stored[k].addr == a && stored[k].mask == m)
                return k;
        end
        return -1;
    endfunction

    function automatic table_rsp_t predict_table_op(input logic [FUNC_W-1:0] op,
                                                    input logic [ADDR_W-1:0] a,
                                                    input logic [ADDR_W-1:0] m);
        table_rsp_t r;
        int         k;
        entry_t     e;
        r = '0;
        r.status = STATUS_OK;
        case (op)
            OP_APPEND:
            begin
                // a full table refuses even a duplicate
                if (stored.size() >= TABLE_DEPTH)
                    r.status = STATUS_FULL;
                else if (find_pair(a, m) >= 0)
                    r.status = STATUS_EXISTS;
                else
                begin
                    e.addr = a;
                    e.mask = m;
                    stored.push_back(e);
                end
            end
            OP_DELETE:
            begin
                k = find_pair(a, m);
                if (k < 0)
                    r.status = STATUS_NOT_FOUND;
                else
                    stored.delete(k);
            end
            OP_MATCH:
            begin
                foreach (stored[i])
                begin
                    if (stored[i].addr == (a & stored[i].mask))
                        r.matched = 1'b1;
                end
            end
            default:
                stored.delete();
        endcase
        r.count = COUNT_OUT_W'(stored.size());
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_mask();
        int len;
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2, 3:
            begin
                len = $urandom_range(1, 32);
                return 32'hFFFF_FFFF << (32 - len);
            end
            default: return $urandom;
        endcase
    endfunction

    // drive one transaction from a falling edge, return at the falling edge after it
    task automatic send_op(input logic [FUNC_W-1:0] op, input logic [ADDR_W-1:0] a,
                           input logic [ADDR_W-1:0] m);
        int         gap;
        table_rsp_t r;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.func  = op;
        req_ch.addr  = a;
        req_ch.mask  = m;
        do @(posedge clk); while (!req_ch.ready);
        r = predict_table_op(op, a, m);
        pending_rsp.push_back(r);
        op_seen[op]++;
        if (r.status == STATUS_FULL) full_seen++;
        if (r.status == STATUS_EXISTS) dup_seen++;
        if (r.status == STATUS_NOT_FOUND) miss_seen++;
        if (r.matched) hit_seen++;
        if (stored.size() > peak_entries) peak_entries = stored.size();
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        req_ch.valid = 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_empty_table();
        send_op(OP_MATCH, $urandom, $urandom);
        send_op(OP_DELETE, $urandom, $urandom);
        send_op(OP_FLUSH, $urandom, $urandom);
    endtask

    task automatic test_basic_ops();
        send_op(OP_APPEND, 32'h0000_0000, 32'h0000_0000);
        send_op(OP_MATCH, 32'hFFFF_FFFF, $urandom);
        send_op(OP_APPEND, 32'h0000_0000, 32'h0000_0000);
        send_op(OP_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_APPEND, 32'h0000_0000, 32'hFFFF_FFFF);
        send_op(OP_DELETE, 32'h0000_0000, 32'h0000_0000);
        send_op(OP_MATCH, 32'h1234_5678, $urandom);
        send_op(OP_MATCH, 32'hFFFF_FFFF, $urandom);
        // address bits outside the mask: this entry can never match
        send_op(OP_APPEND, 32'h0000_0001, 32'h0000_0000);
        send_op(OP_MATCH, 32'h0000_0001, $urandom);
        send_op(OP_DELETE, 32'h0000_0001, 32'h0000_0001);
        send_op(OP_APPEND, 32'hC0A8_0000, 32'hFFFF_0000);
        send_op(OP_MATCH, 32'hC0A8_12AB, $urandom);
        send_op(OP_MATCH, 32'hC0A9_0000, $urandom);
        send_op(OP_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_FLUSH, $urandom, $urandom);
        send_op(OP_MATCH, 32'h0000_0000, $urandom);
    endtask

    task automatic test_random_traffic(input int n);
        int                sel, r, k;
        logic [ADDR_W-1:0] a, m;
        for (int i = 0; i < n; i++)
        begin
            if (i % 120 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            if (i == n / 2)
                wait_for_results();
            sel = $urandom_range(0, 99);
            if (sel < 42 && stored.size() >= TABLE_CAP)
                sel = 50;
            a = $urandom;
            m = $urandom;
            k = (stored.size() != 0) ? $urandom_range(0, stored.size() - 1) : 0;
            if (sel < 42)
            begin
                if (stored.size() != 0 && $urandom_range(0, 4) == 0)
                begin
                    a = stored[k].addr;
                    m = stored[k].mask;
                end
                else
                begin
                    m = pick_mask();
                    if ($urandom_range(0, 4) != 0)
                        a = a & m;
                end
                send_op(OP_APPEND, a, m);
            end
            else if (sel < 66)
            begin
                r = $urandom_range(0, 9);
                if (stored.size() != 0 && r < 7)
                begin
                    a = stored[k].addr;
                    m = stored[k].mask;
                end
                else if (stored.size() != 0 && r < 8)
                begin
                    a = stored[k].addr;
                    m = stored[k].mask ^ (32'h1 << $urandom_range(0, 31));
                end
                send_op(OP_DELETE, a, m);
            end
            else if (sel < 97)
            begin
                if (stored.size() != 0 && $urandom_range(0, 1) == 0)
                    a = stored[k].addr | (a & ~stored[k].mask);
                send_op(OP_MATCH, a, m);
            end
            else
                send_op(OP_FLUSH, a, m);
        end
        no_idle = 1'b0;
    endtask

    // response side holds ready low for a random stall before each transaction unless no_idle is set
    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall != 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready = 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        table_rsp_t exp_rsp;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("unexpected response: status %0d matched %0d entry_count %0d",
                       rsp_ch.status, rsp_ch.matched, rsp_ch.entry_count);
                errors++;
            end
            else
            begin
                exp_rsp = pending_rsp.pop_front();
                if (rsp_ch.status !== exp_rsp.status)
                begin
                    $error("status mismatch: expected %0d, got %0d",
                           exp_rsp.status, rsp_ch.status);
                    errors++;
                end
                if (rsp_ch.matched !== exp_rsp.matched)
                begin
                    $error("matched mismatch: expected %0d, got %0d",
                           exp_rsp.matched, rsp_ch.matched);
                    errors++;
                end
                if (rsp_ch.entry_count !== exp_rsp.count)
                begin
                    $error("entry_count mismatch: expected %0d, got %0d",
                           exp_rsp.count, rsp_ch.entry_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycles, pending_rsp.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.func  = OP_APPEND;
        req_ch.addr  = '0;
        req_ch.mask  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_basic_ops();
        test_random_traffic(560);

        wait_for_results();
        repeat (TABLE_DEPTH + 16) @(posedge clk);
        if (pending_rsp.size() != 0)
        begin
            $error("%0d responses never arrived", pending_rsp.size());
            errors++;
        end

        $display("ran %0d appends, %0d deletes, %0d matches, %0d flushes",
                 op_seen[OP_APPEND], op_seen[OP_DELETE], op_seen[OP_MATCH],
                 op_seen[OP_FLUSH]);
        $display("saw %0d full, %0d duplicate, %0d not found, %0d hits; peak %0d entries",
                 full_seen, dup_seen, miss_seen, hit_seen, peak_entries);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
